@@ hdl/mec_pkg.sv @@
package mec_pkg;

	// default sizes
	localparam int COORD_WIDTH_DEF = 32;
	localparam int ITER_WIDTH_DEF  = 16;
	localparam int INDEX_WIDTH_DEF = 12;

	// integer bits above the binary point of a coordinate
	localparam int INT_BITS = 4;

	// register index codes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_START_REAL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_IMAG = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ITER   = 2'd3;

	// reset values, as mantissa and shift below the binary point
	localparam int RST_START_REAL_MANT = -2;
	localparam int RST_START_IMAG_MANT = 5;
	localparam int RST_START_IMAG_DROP = 2;
	localparam int RST_STEP_MANT       = 10;
	localparam int RST_STEP_DROP       = 12;
	localparam int RST_MAX_ITER        = 256;

	// bus data width: 64 once a coordinate no longer fits 32 bits
	function automatic int data_w(input int cw);
		return (cw > 32) ? 64 : 32;
	endfunction

	// byte address width for four registers at 4 or 8 byte spacing
	function automatic int addr_w(input int cw);
		return (cw > 32) ? 5 : 4;
	endfunction

endpackage

@@ hdl/mec_regs.sv @@
module mec_regs #(
	parameter int COORD_WIDTH = mec_pkg::COORD_WIDTH_DEF,
	parameter int ITER_WIDTH  = mec_pkg::ITER_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        psel,
	input  logic                                        penable,
	input  logic                                        pwrite,
	input  logic [mec_pkg::addr_w(COORD_WIDTH)-1:0]     paddr,
	input  logic [mec_pkg::data_w(COORD_WIDTH)-1:0]     pwdata,
	output logic [mec_pkg::data_w(COORD_WIDTH)-1:0]     prdata,
	output logic signed [COORD_WIDTH-1:0]               start_real,
	output logic signed [COORD_WIDTH-1:0]               start_imag,
	output logic [COORD_WIDTH-2:0]                      step_size,
	output logic [ITER_WIDTH-1:0]                       max_iterations
);

	localparam int AW   = mec_pkg::addr_w(COORD_WIDTH);
	localparam int DW   = mec_pkg::data_w(COORD_WIDTH);
	localparam int FRAC = COORD_WIDTH - mec_pkg::INT_BITS;

	localparam logic signed [COORD_WIDTH-1:0] START_REAL_RST =
		COORD_WIDTH'(mec_pkg::RST_START_REAL_MANT) <<< FRAC;
	localparam logic signed [COORD_WIDTH-1:0] START_IMAG_RST =
		COORD_WIDTH'(mec_pkg::RST_START_IMAG_MANT) << (FRAC - mec_pkg::RST_START_IMAG_DROP);
	localparam logic [COORD_WIDTH-2:0] STEP_RST =
		(COORD_WIDTH-1)'(mec_pkg::RST_STEP_MANT) << (FRAC - mec_pkg::RST_STEP_DROP);
	localparam logic [ITER_WIDTH-1:0] MAX_ITER_RST = ITER_WIDTH'(mec_pkg::RST_MAX_ITER);

	logic [mec_pkg::REG_IDX_W-1:0] idx;
	logic                          wr_en;
	logic signed [COORD_WIDTH-1:0] start_real_q;
	logic signed [COORD_WIDTH-1:0] start_imag_q;
	logic [COORD_WIDTH-2:0]        step_q;
	logic [ITER_WIDTH-1:0]         max_iter_q;

	assign idx   = paddr[AW-1:AW-mec_pkg::REG_IDX_W];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_real_q <= START_REAL_RST;
			start_imag_q <= START_IMAG_RST;
			step_q       <= STEP_RST;
			max_iter_q   <= MAX_ITER_RST;
		end else if (wr_en) begin
			case (idx)
				mec_pkg::REG_START_REAL: start_real_q <= pwdata[COORD_WIDTH-1:0];
				mec_pkg::REG_START_IMAG: start_imag_q <= pwdata[COORD_WIDTH-1:0];
				mec_pkg::REG_STEP_SIZE:  step_q       <= pwdata[COORD_WIDTH-2:0];
				mec_pkg::REG_MAX_ITER:   max_iter_q   <= pwdata[ITER_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mec_pkg::REG_START_REAL: prdata = DW'($unsigned(start_real_q));
			mec_pkg::REG_START_IMAG: prdata = DW'($unsigned(start_imag_q));
			mec_pkg::REG_STEP_SIZE:  prdata = DW'(step_q);
			mec_pkg::REG_MAX_ITER:   prdata = DW'(max_iter_q);
			default:                 prdata = '0;
		endcase
	end

	assign start_real     = start_real_q;
	assign start_imag     = start_imag_q;
	assign step_size      = step_q;
	assign max_iterations = max_iter_q;

endmodule

@@ hdl/mec_cmul.sv @@
module mec_cmul #(
	parameter int OPW = mec_pkg::COORD_WIDTH_DEF + 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [OPW-1:0]   a0,
	input  logic signed [OPW-1:0]   b0,
	input  logic signed [OPW-1:0]   a1,
	input  logic signed [OPW-1:0]   b1,
	input  logic signed [OPW-1:0]   a2,
	input  logic signed [OPW-1:0]   b2,
	output logic signed [2*OPW-1:0] p0,
	output logic signed [2*OPW-1:0] p1,
	output logic signed [2*OPW-1:0] p2
);

	// three products per cycle, registered; held when not enabled
	logic signed [2*OPW-1:0] p0_q;
	logic signed [2*OPW-1:0] p1_q;
	logic signed [2*OPW-1:0] p2_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_q <= (2*OPW)'(a0) * (2*OPW)'(b0);
			p1_q <= (2*OPW)'(a1) * (2*OPW)'(b1);
			p2_q <= (2*OPW)'(a2) * (2*OPW)'(b2);
		end
	end

	assign p0 = p0_q;
	assign p1 = p1_q;
	assign p2 = p2_q;

endmodule

@@ hdl/mandelbrot_escape_count_top.sv @@
// channel  dir  handshake            payload
// pixel    in   in_valid/in_ready    pixel_row, pixel_col
// result   out  out_valid/out_ready  escape_count
// config   in   psel/penable/pready  paddr, pwdata, prdata (apb, write in access phase)
//
// a pixel first forms the index products, then c, then runs its rounds on the single
// squaring unit (each round: products, then add c and bounds test)
// out_valid rises after a bounds escape, after a magnitude-only escape, or once the
// round limit is passed with no escape
// in_ready is high only in idle; a finished count waits in the output register, so
// the next pixel runs meanwhile and stalls on its finish; reset restores defaults
module mandelbrot_escape_count_top #(
	parameter int COORD_WIDTH = mec_pkg::COORD_WIDTH_DEF,
	parameter int ITER_WIDTH  = mec_pkg::ITER_WIDTH_DEF,
	parameter int INDEX_WIDTH = mec_pkg::INDEX_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [INDEX_WIDTH-1:0]                  pixel_row,
	input  logic [INDEX_WIDTH-1:0]                  pixel_col,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [ITER_WIDTH-1:0]                   escape_count,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [mec_pkg::addr_w(COORD_WIDTH)-1:0] paddr,
	input  logic [mec_pkg::data_w(COORD_WIDTH)-1:0] pwdata,
	output logic [mec_pkg::data_w(COORD_WIDTH)-1:0] prdata,
	output logic                                    pready
);

	localparam int FRAC = COORD_WIDTH - mec_pkg::INT_BITS;
	localparam int OPW  = COORD_WIDTH + 1;     // operand width, holds an index too
	localparam int PW   = 2 * OPW;             // product width
	localparam int RW   = PW + 2;              // width of c and of a new z
	localparam int SW   = PW + 1;              // width of |z|^2

	// 2.0 at FRAC fraction bits, 4.0 at 2*FRAC
	localparam logic signed [RW-1:0] TWO      = RW'(2) <<< FRAC;
	localparam logic signed [RW-1:0] TWO_NEG  = -TWO;
	localparam logic [SW-1:0]        FOUR_SQ  = SW'(4) << (2 * FRAC);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INIT   = 3'd1;   // col*step, row*step
	localparam logic [2:0] S_CADD   = 3'd2;   // form c, clear products
	localparam logic [2:0] S_ROUND  = 3'd3;   // new z, bounds and limit tests
	localparam logic [2:0] S_SQUARE = 3'd4;   // squares and cross product of z

	logic signed [COORD_WIDTH-1:0] start_real;
	logic signed [COORD_WIDTH-1:0] start_imag;
	logic [COORD_WIDTH-2:0]        step_size;
	logic [ITER_WIDTH-1:0]         max_iterations;

	logic [2:0]                    state_q;
	logic [INDEX_WIDTH-1:0]        row_q;
	logic [INDEX_WIDTH-1:0]        col_q;
	logic signed [RW-1:0]          c_re_q;
	logic signed [RW-1:0]          c_im_q;
	logic signed [COORD_WIDTH-1:0] zr_q;
	logic signed [COORD_WIDTH-1:0] zi_q;
	logic [ITER_WIDTH:0]           iter_q;    // round number, one past the limit at most
	logic                          test_q;    // products hold the squares of the last z
	logic                          out_valid_q;
	logic [ITER_WIDTH-1:0]         count_q;

	logic                          mul_en;
	logic signed [OPW-1:0]         a0, b0, a1, b1, a2, b2;
	logic signed [PW-1:0]          p0, p1, p2;

	logic signed [RW-1:0]          diff;
	logic signed [RW-1:0]          nr;
	logic signed [RW-1:0]          ni;
	logic [SW-1:0]                 mag_sq;
	logic                          esc_mag;
	logic                          at_limit;
	logic                          esc_bound;
	logic                          finish;
	logic [ITER_WIDTH-1:0]         finish_count;
	logic                          out_free;

	mec_regs #(
		.COORD_WIDTH(COORD_WIDTH),
		.ITER_WIDTH (ITER_WIDTH)
	) u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.start_real    (start_real),
		.start_imag    (start_imag),
		.step_size     (step_size),
		.max_iterations(max_iterations)
	);

	assign pready = 1'b1;

	// operand select for the shared multiplier; zero while forming c so the
	// first round sees z = 0
	always_comb begin
		a0 = '0;
		b0 = '0;
		a1 = '0;
		b1 = '0;
		a2 = '0;
		b2 = '0;
		case (state_q)
			S_INIT: begin
				a0 = $signed(OPW'(col_q));
				b0 = $signed(OPW'(step_size));
				a1 = $signed(OPW'(row_q));
				b1 = $signed(OPW'(step_size));
			end
			S_SQUARE: begin
				a0 = OPW'(zr_q);
				b0 = OPW'(zr_q);
				a1 = OPW'(zi_q);
				b1 = OPW'(zi_q);
				a2 = OPW'(zr_q);
				b2 = OPW'(zi_q);
			end
			default: ;
		endcase
	end

	assign mul_en = (state_q == S_INIT) || (state_q == S_CADD) || (state_q == S_SQUARE);

	mec_cmul #(
		.OPW(OPW)
	) u_cmul (
		.clk(clk),
		.en (mul_en),
		.a0 (a0),
		.b0 (b0),
		.a1 (a1),
		.b1 (b1),
		.a2 (a2),
		.b2 (b2),
		.p0 (p0),
		.p1 (p1),
		.p2 (p2)
	);

	// one round: re = floor((zr^2 - zi^2) / 2^f) + c_re, im = floor(zr*zi / 2^(f-1)) + c_im
	assign diff = RW'(p0) - RW'(p1);
	assign nr   = (diff >>> FRAC) + c_re_q;
	assign ni   = (RW'(p2) >>> (FRAC - 1)) + c_im_q;

	// squares are never negative, so an unsigned sum is exact
	assign mag_sq  = SW'($unsigned(p0)) + SW'($unsigned(p1));
	assign esc_mag = test_q && (mag_sq > FOUR_SQ);

	assign at_limit  = iter_q > {1'b0, max_iterations};
	assign esc_bound = (nr > TWO) || (nr < TWO_NEG) || (ni > TWO) || (ni < TWO_NEG);
	assign finish    = esc_mag || at_limit || esc_bound;

	// magnitude test belongs to the previous round, so it wins
	always_comb begin
		if (esc_mag) begin
			finish_count = ITER_WIDTH'(iter_q - 1'b1);
		end else if (at_limit) begin
			finish_count = max_iterations;
		end else begin
			finish_count = ITER_WIDTH'(iter_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			test_q      <= 1'b0;
			iter_q      <= '0;
		end else begin
			// a new count replaces a taken one in the same cycle
			if (state_q == S_ROUND && finish && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					state_q <= S_CADD;
				end
				S_CADD: begin
					iter_q  <= (ITER_WIDTH+1)'(1);
					test_q  <= 1'b0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					if (finish) begin
						// hold here until the output register frees up
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					iter_q  <= iter_q + 1'b1;
					test_q  <= 1'b1;
					state_q <= S_ROUND;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			row_q <= pixel_row;
			col_q <= pixel_col;
		end
		if (state_q == S_CADD) begin
			c_re_q <= RW'(start_real) + RW'(p0);
			c_im_q <= RW'(start_imag) - RW'(p1);
		end
		if (state_q == S_ROUND && !finish) begin
			zr_q <= nr[COORD_WIDTH-1:0];
			zi_q <= ni[COORD_WIDTH-1:0];
		end
		if (state_q == S_ROUND && finish && out_free) begin
			count_q <= finish_count;
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign escape_count = count_q;

	// an accepted pixel starts with the index products
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_INIT)
		else $error("pixel accepted but set-up not started");

	// the round counter never runs more than one past the limit
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUND |-> iter_q <= {1'b0, max_iterations} + 1'b1)
		else $error("round counter past limit");

	// a stored z lies inside the radius-two box
	a_z_box: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQUARE |->
			(RW'(zr_q) <= TWO) && (RW'(zr_q) >= TWO_NEG) &&
			(RW'(zi_q) <= TWO) && (RW'(zi_q) >= TWO_NEG))
		else $error("stored z outside bounds");

	// a new count never exceeds the limit
	a_count_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> count_q <= max_iterations)
		else $error("escape count above limit");

endmodule
